### src/krrl_pkg.sv
package krrl_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned NumW  = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [TimeW-1:0] WindowReset = 32'd30000;

  localparam logic ReqCheck = 1'b0;
  localparam logic ReqClear = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [NumW-1:0]  num;
    logic [TimeW-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

### src/keyed_repeat_rate_limiter.sv
// Keyed repeat rate limiter.
// Requests arrive on the in_* valid/ready channel. A check request
// (req_type_i = 0) carries a station key, a message number and a time
// stamp in ms; a clear request (req_type_i = 1) empties the pair table.
// Each request yields exactly one response on the out_* valid/ready
// channel: allowed_o and pair_known_o.
// The pair table sits in a single RAM with registered read; one compare
// and subtract unit walks it entry by entry, reading each entry in S_READ
// and comparing it in S_CMP. Clear or missing-key requests go straight to
// the response; a check scans until the pair hits or, on a miss, until the
// last entry, where the pair is inserted. The next request can be accepted
// in the same cycle that the response goes valid.
// The response sits in an output register; a stalled receiver holds it
// there and the next request may be accepted meanwhile, but its response
// waits until the register drains.
// The window register is written on the cfg_* channel (always ready)
// and should only change while the block is idle.
// Reset empties the table, zeroes the victim pointer and sets the window
// to 30000 ms.
module keyed_repeat_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned KEY_CHARS     = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [krrl_pkg::TimeW-1:0]  cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic                        key_present_i,
  input  logic [krrl_pkg::KeyW-1:0]   station_key_i,
  input  logic [krrl_pkg::NumW-1:0]   message_number_i,
  input  logic [krrl_pkg::TimeW-1:0]  now_ms_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        allowed_o,
  output logic                        pair_known_o
);

  import krrl_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KeyBytes = KeyW / 8;

  state_e             state_q, state_d;
  logic [TimeW-1:0]   window_q;
  logic [KeyW-1:0]    key_q, key_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               free_found_q, free_found_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  logic [IdxW-1:0]    vptr_q, vptr_d;
  logic [TABLE_ENTRIES-1:0] used_q, used_d;
  logic               res_allowed_q, res_allowed_d;
  logic               res_known_q, res_known_d;
  logic               out_valid_q, out_valid_d;
  logic               allowed_q, allowed_d;
  logic               known_q, known_d;

  logic               in_fire;
  logic [KeyW-1:0]    key_form;
  logic [CntW-1:0]    idx_next;
  logic               last;
  logic [IdxW-1:0]    cur_idx;
  logic               cur_used;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               hit;
  logic [TimeW-1:0]   elapsed;
  logic               too_soon;
  logic               free_any;
  logic [IdxW-1:0]    ins_slot;
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic               ram_re;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;

  // Keep only the first KEY_CHARS bytes, and zero everything from the first NUL on.
  always_comb begin
    logic alive;
    alive    = 1'b1;
    key_form = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (alive && (i < KEY_CHARS) && (station_key_i[i*8 +: 8] != 8'h00)) begin
        key_form[i*8 +: 8] = station_key_i[i*8 +: 8];
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign idx_next = idx_q + 1'b1;
  assign last     = (idx_next == CntW'(TABLE_ENTRIES));
  assign cur_idx  = idx_q[IdxW-1:0];
  assign cur_used = used_q[cur_idx];

  // Shared compare and subtract unit
  assign hit      = cur_used && (rd_entry.key == key_q) && (rd_entry.num == num_q);
  assign elapsed  = now_q - rd_entry.stamp;
  assign too_soon = (elapsed < window_q);

  assign free_any = free_found_q | ~cur_used;
  assign ins_slot = free_found_q ? free_idx_q : (cur_used ? vptr_q : cur_idx);

  assign ram_re   = (state_q == S_READ);
  assign wr_entry = '{key: key_q, num: num_q, stamp: now_q};

  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    num_d         = num_q;
    now_d         = now_q;
    idx_d         = idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    vptr_d        = vptr_q;
    used_d        = used_q;
    res_allowed_d = res_allowed_q;
    res_known_d   = res_known_q;
    out_valid_d   = out_valid_q;
    allowed_d     = allowed_q;
    known_d       = known_q;
    ram_we        = 1'b0;
    ram_waddr     = cur_idx;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d         = key_form;
          num_d         = message_number_i;
          now_d         = now_ms_i;
          idx_d         = '0;
          free_found_d  = 1'b0;
          res_allowed_d = 1'b0;
          res_known_d   = 1'b0;
          if (req_type_i == ReqClear) begin
            used_d  = '0;
            vptr_d  = '0;
            state_d = S_DONE;
          end else if (!key_present_i) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          res_known_d = 1'b1;
          state_d     = S_DONE;
          if (!too_soon) begin
            // refresh the stamp of the matching entry
            res_allowed_d = 1'b1;
            ram_we        = 1'b1;
            ram_waddr     = cur_idx;
          end
        end else if (last) begin
          res_allowed_d     = 1'b1;
          ram_we            = 1'b1;
          ram_waddr         = ins_slot;
          used_d[ins_slot]  = 1'b1;
          vptr_d            = (ins_slot == IdxW'(TABLE_ENTRIES - 1)) ? '0 : ins_slot + 1'b1;
          state_d           = S_DONE;
        end else begin
          if (!free_found_q && free_any) begin
            free_found_d = 1'b1;
            free_idx_d   = cur_idx;
          end
          idx_d   = idx_next;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          allowed_d   = res_allowed_q;
          known_d     = res_known_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  krrl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (cur_idx),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      window_q     <= WindowReset;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      vptr_q       <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      vptr_q       <= vptr_d;
      used_q       <= used_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    num_q         <= num_d;
    now_q         <= now_d;
    free_idx_q    <= free_idx_d;
    res_allowed_q <= res_allowed_d;
    res_known_q   <= res_known_d;
    allowed_q     <= allowed_d;
    known_q       <= known_d;
  end

  assign out_valid_o  = out_valid_q;
  assign allowed_o    = allowed_q;
  assign pair_known_o = known_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_write_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CMP))
    else $error("table write outside compare step");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> $past(state_q == S_READ))
    else $error("compare without a preceding read");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i == ReqClear)) |=> (used_q == '0) && (vptr_q == '0))
    else $error("clear request left entries in use");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_READ) || (state_q == S_CMP)) |-> (idx_q < CntW'(TABLE_ENTRIES)))
    else $error("scan index beyond table");

endmodule

### src/krrl_ram.sv
module krrl_ram #(
  parameter int unsigned WIDTH = 112,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
